// ===== rtl/core/epcl_pkg.sv =====
// Shared types, register indexes and helpers for the eta/phi cell locator.
package epcl_pkg;

    localparam int Q_W       = 16;  // signed fixed-point field width
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int ETA_NUM_W = 17;  // eta + max_abs_eta, always non-negative
    localparam int REM_W     = 15;  // divider remainder, below a 15-bit divisor
    localparam int LYR_W     = 8;   // widest layer field carried internally

    // pi in unsigned Q32
    localparam longint PI_Q32 = 64'sd13493037705;

    typedef logic signed [Q_W-1:0]       t_q;
    typedef logic [CFG_IDX_W-1:0]        t_cfg_addr;
    typedef logic [CFG_DAT_W-1:0]        t_cfg_data;

    typedef enum logic {
        OP_LOCATE   = 1'b0,
        OP_DESCRIBE = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLING_LAYER = 3'd0,
        CFG_MAX_ABS_ETA    = 3'd1,
        CFG_ETA_WIDTH      = 3'd2,
        CFG_PHI_WIDTH      = 3'd3,
        CFG_ETA_BIN_COUNT  = 3'd4,
        CFG_PHI_BIN_COUNT  = 3'd5
    } t_cfg_idx;

    // saturate a wide signed value to the 16-bit signed range
    function automatic t_q sat16(input logic signed [32:0] v);
        logic signed [32:0] hi;
        logic signed [32:0] lo;
        hi = 33'sd32767;
        lo = -33'sd32768;
        if (v > hi) begin
            sat16 = 16'sh7fff;
        end else if (v < lo) begin
            sat16 = 16'sh8000;
        end else begin
            sat16 = t_q'(v[Q_W-1:0]);
        end
    endfunction

endpackage

// ===== rtl/core/eta_phi_cell_locator.sv =====
// Top level of the eta/phi cell locator: pipelined locate and describe of calorimeter cells.
//
// Usage
//   Requests enter on start while busy is low; busy is only high during reset,
//   so one request may enter every clock. A locate request takes i_eta_in and
//   i_phi_in (signed Q4.12); a describe request takes layer, side and the two
//   bin indexes. Each request gives exactly one result, shown for one cycle
//   with o_valid high; the receiver cannot hold results off, and none is needed.
//   When o_found is low every other result field is zero.
// Throughput and pipeline
//   One request per cycle outside reset. A request passes the entry register,
//   the NS divider stages, then the bin selection, edge product and edge
//   registers and the result register; NS = max(17, KS + WW) covers 17 steps of
//   the eta bin divider, KS steps of the constant 2pi reduction of phi, then
//   WW steps of the phi bin divider (WW = bits of 2pi in FRAC_BITS).
//   Each divider stage does one restoring-division step.
// Configuration
//   i_cfg_valid/o_cfg_ready with a register index and data; write only while
//   no request is in flight. Reset (synchronous, i_rst_n low) restores the
//   register defaults and empties the pipeline; requests and writes are held
//   off while reset is held.
module eta_phi_cell_locator #(
    parameter int ETA_INDEX_BITS = 10,
    parameter int PHI_INDEX_BITS = 8,
    parameter int LAYER_BITS     = 4,
    parameter int FRAC_BITS      = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_operation,
    input  epcl_pkg::t_q                  i_eta_in,
    input  epcl_pkg::t_q                  i_phi_in,
    input  logic [LAYER_BITS-1:0]         i_layer_in,
    input  logic                          i_side_in,
    input  logic [ETA_INDEX_BITS-1:0]     i_eta_bin_in,
    input  logic [PHI_INDEX_BITS-1:0]     i_phi_bin_in,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  epcl_pkg::t_cfg_addr           i_cfg_index,
    input  epcl_pkg::t_cfg_data           i_cfg_data,
    // result
    output logic                          o_valid,
    output logic                          o_found,
    output logic [LAYER_BITS+ETA_INDEX_BITS+PHI_INDEX_BITS:0] o_cell_code,
    output logic                          o_side_out,
    output logic [ETA_INDEX_BITS-1:0]     o_eta_bin_out,
    output logic [PHI_INDEX_BITS-1:0]     o_phi_bin_out,
    output epcl_pkg::t_q                  o_eta_low,
    output epcl_pkg::t_q                  o_eta_high,
    output epcl_pkg::t_q                  o_phi_low,
    output epcl_pkg::t_q                  o_phi_high,
    output epcl_pkg::t_q                  o_eta_mid,
    output epcl_pkg::t_q                  o_phi_mid
);
    import epcl_pkg::*;

    // fixed-point pi and the phi reduction geometry
    localparam longint PI_FIX     = (PI_Q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
    localparam longint TWO_PI_FIX = 2 * PI_FIX;
    // multiples of 2pi added so that phi + pi is never negative
    localparam longint WRAP_M     = (64'sd32768 + TWO_PI_FIX - 1) / TWO_PI_FIX;
    localparam longint PHI_OFFS   = PI_FIX + WRAP_M * TWO_PI_FIX;
    localparam int     WX         = $clog2(64'sd32767 + PHI_OFFS + 1);
    localparam int     WW         = $clog2(TWO_PI_FIX);
    localparam int     KS         = WX - WW + 1;
    localparam int     NS         = (ETA_NUM_W > KS + WW) ? ETA_NUM_W : KS + WW;
    localparam int     PIW        = (WW > PHI_INDEX_BITS) ? WW : PHI_INDEX_BITS;
    localparam int     CW         = LAYER_BITS + ETA_INDEX_BITS + PHI_INDEX_BITS + 1;
    localparam int     LATENCY    = NS + 5;

    typedef struct packed {
        logic                   valid;
        t_op                    op;
        logic                   bad;       // locate rejected up front
        logic                   side;
        logic                   eta_max;
        logic                   eta_zero;
        logic [LYR_W-1:0]       layer;
        logic [ETA_NUM_W-1:0]   e_num;
        logic [REM_W-1:0]       e_rem;
        logic [ETA_NUM_W-1:0]   e_q;       // eta bin (describe: preloaded)
        logic [WX-1:0]          p_x;       // phi + offset, reduced mod 2pi
        logic [REM_W-1:0]       p_rem;
        logic [PIW-1:0]         p_q;       // phi bin (describe: preloaded)
    } t_stage;

    typedef struct packed {
        logic           valid;
        logic           ok;
        logic           side;
        logic           even_lo;   // last bin below the middle, even count
        logic           even_hi;   // middle bin, even count
        logic [10:0]    ei;
        logic [8:0]     pi;
        logic [CW-1:0]  code;
    } t_sel;

    typedef struct packed {
        logic           valid;
        logic           ok;
        logic           side;
        logic           even_lo;
        logic           even_hi;
        logic [25:0]    prod_e;
        logic [23:0]    prod_p;
        logic [CW-1:0]  code;
    } t_mul;

    typedef struct packed {
        logic               valid;
        logic               ok;
        logic signed [31:0] e_lo;
        logic signed [31:0] e_hi;
        logic signed [31:0] p_lo;
        logic signed [31:0] p_hi;
        logic [CW-1:0]      code;
    } t_edge;

    // configuration registers
    logic [3:0]  r_cfg_layer;
    logic [14:0] r_max_eta;
    logic [14:0] r_eta_width;
    logic [14:0] r_phi_width;
    logic [10:0] r_eta_count;
    logic [8:0]  r_phi_count;

    assign busy        = ~i_rst_n;
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_layer <= 4'd0;
            r_max_eta   <= 15'd10240;
            r_eta_width <= 15'd512;
            r_phi_width <= 15'd402;
            r_eta_count <= 11'd40;
            r_phi_count <= 9'd64;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SAMPLING_LAYER: r_cfg_layer <= i_cfg_data[3:0];
                CFG_MAX_ABS_ETA:    r_max_eta   <= i_cfg_data[14:0];
                CFG_ETA_WIDTH:      r_eta_width <= i_cfg_data[14:0];
                CFG_PHI_WIDTH:      r_phi_width <= i_cfg_data[14:0];
                CFG_ETA_BIN_COUNT:  r_eta_count <= i_cfg_data[10:0];
                CFG_PHI_BIN_COUNT:  r_phi_count <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // ---- entry stage: range checks, dividend set-up -------------------------
    t_stage r_st [0:NS];
    t_stage n_st0;
    logic signed [16:0] eta17;
    logic signed [16:0] mx17;

    always_comb begin
        eta17         = 17'(i_eta_in);
        mx17          = signed'({2'b00, r_max_eta});
        n_st0         = '0;
        n_st0.valid   = start & ~busy;   // busy also clears the stage in reset
        n_st0.op      = t_op'(i_operation);
        n_st0.e_num   = ETA_NUM_W'(eta17 + mx17);
        n_st0.p_x     = WX'(longint'(i_phi_in) + PHI_OFFS);
        n_st0.eta_max = (eta17 == mx17);
        n_st0.eta_zero = (i_eta_in == '0);
        if (t_op'(i_operation) == OP_DESCRIBE) begin
            n_st0.side  = i_side_in;
            n_st0.layer = LYR_W'(i_layer_in);
            n_st0.e_q   = ETA_NUM_W'(i_eta_bin_in);
            n_st0.p_q   = PIW'(i_phi_bin_in);
        end else begin
            n_st0.side  = ~i_eta_in[Q_W-1];
            n_st0.layer = LYR_W'(r_cfg_layer);
            n_st0.bad   = (eta17 < -mx17) || (eta17 > mx17) ||
                          (r_eta_width == '0) || (r_phi_width == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= n_st0;
    end

    // ---- one division step per stage ----------------------------------------
    for (genvar s = 0; s < NS; s++) begin : g_step
        localparam int         EBIT = (s < ETA_NUM_W) ? ETA_NUM_W - 1 - s : 0;
        localparam int         SH   = (s < KS) ? KS - 1 - s : 0;
        localparam int         PBIT = (s >= KS && s < KS + WW) ? WW - 1 - (s - KS) : 0;
        localparam logic [63:0] MODC = 64'(TWO_PI_FIX) << SH;

        t_stage      n_st;
        logic [15:0] e_try;
        logic [15:0] p_try;

        always_comb begin
            n_st       = r_st[s];
            n_st.valid = r_st[s].valid & i_rst_n;
            e_try = {r_st[s].e_rem, r_st[s].e_num[EBIT]};
            p_try = {r_st[s].p_rem, r_st[s].p_x[PBIT]};
            if (r_st[s].op == OP_LOCATE) begin
                if (s < ETA_NUM_W) begin
                    if (e_try >= {1'b0, r_eta_width}) begin
                        n_st.e_rem = REM_W'(e_try - {1'b0, r_eta_width});
                        n_st.e_q   = {r_st[s].e_q[ETA_NUM_W-2:0], 1'b1};
                    end else begin
                        n_st.e_rem = e_try[REM_W-1:0];
                        n_st.e_q   = {r_st[s].e_q[ETA_NUM_W-2:0], 1'b0};
                    end
                end
                if (s < KS) begin
                    if (64'(r_st[s].p_x) >= MODC) begin
                        n_st.p_x = WX'(64'(r_st[s].p_x) - MODC);
                    end
                end
                if (s >= KS && s < KS + WW) begin
                    if (p_try >= {1'b0, r_phi_width}) begin
                        n_st.p_rem = REM_W'(p_try - {1'b0, r_phi_width});
                        n_st.p_q   = {r_st[s].p_q[PIW-2:0], 1'b1};
                    end else begin
                        n_st.p_rem = p_try[REM_W-1:0];
                        n_st.p_q   = {r_st[s].p_q[PIW-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_st[s+1] <= n_st;
        end
    end

    // ---- bin selection and address checks -----------------------------------
    t_stage               fin;
    t_sel                 r_sel;
    t_sel                 n_sel;
    logic [ETA_NUM_W-1:0] ei;
    logic [ETA_NUM_W-1:0] mid;
    logic                 side_ok;

    assign fin = r_st[NS];

    always_comb begin
        mid = ETA_NUM_W'(r_eta_count >> 1);
        if (fin.op == OP_DESCRIBE) begin
            ei = fin.e_q;
        end else if (fin.eta_max) begin
            ei = ETA_NUM_W'(r_eta_count) - 1'b1;
        end else if (fin.eta_zero) begin
            ei = mid;
        end else begin
            ei = fin.e_q;
        end

        if (!r_eta_count[0]) begin
            side_ok = (fin.side == (ei >= mid));
        end else begin
            side_ok = !((ei < mid) && fin.side) && !((ei > mid) && !fin.side);
        end

        n_sel.valid   = fin.valid & i_rst_n;
        n_sel.ok      = !fin.bad && side_ok &&
                        (fin.layer == LYR_W'(r_cfg_layer)) &&
                        ((fin.layer >> LAYER_BITS) == '0) &&
                        (ei < ETA_NUM_W'(r_eta_count)) &&
                        ((ei >> ETA_INDEX_BITS) == '0) &&
                        (fin.p_q < PIW'(r_phi_count)) &&
                        ((fin.p_q >> PHI_INDEX_BITS) == '0);
        n_sel.side    = fin.side;
        n_sel.even_lo = !r_eta_count[0] && (ei + 1'b1 == mid);
        n_sel.even_hi = !r_eta_count[0] && (ei == mid);
        n_sel.ei      = ei[10:0];
        n_sel.pi      = 9'(fin.p_q);
        n_sel.code    = {fin.layer[LAYER_BITS-1:0], fin.side,
                         ei[ETA_INDEX_BITS-1:0], fin.p_q[PHI_INDEX_BITS-1:0]};
    end

    always_ff @(posedge i_clk) begin
        r_sel <= n_sel;
    end

    // ---- edge products -------------------------------------------------------
    t_mul r_mul;

    always_ff @(posedge i_clk) begin
        r_mul.valid   <= r_sel.valid & i_rst_n;
        r_mul.ok      <= r_sel.ok;
        r_mul.side    <= r_sel.side;
        r_mul.even_lo <= r_sel.even_lo;
        r_mul.even_hi <= r_sel.even_hi;
        r_mul.prod_e  <= r_sel.ei * r_eta_width;
        r_mul.prod_p  <= r_sel.pi * r_phi_width;
        r_mul.code    <= r_sel.code;
    end

    // ---- edges, clamping at zero eta, empty-cell check -----------------------
    t_edge r_edge;
    t_edge n_edge;

    always_comb begin
        n_edge.valid = r_mul.valid & i_rst_n;
        n_edge.code  = r_mul.code;
        n_edge.e_lo  = signed'({6'b0, r_mul.prod_e}) - signed'({17'b0, r_max_eta});
        n_edge.e_hi  = n_edge.e_lo + signed'({17'b0, r_eta_width});
        if (!r_mul.side) begin
            if (n_edge.e_hi > 0) begin
                n_edge.e_hi = '0;
            end
        end else if (n_edge.e_lo < 0) begin
            n_edge.e_lo = '0;
        end
        if (r_mul.even_lo) begin
            n_edge.e_hi = '0;
        end else if (r_mul.even_hi) begin
            n_edge.e_lo = '0;
        end
        n_edge.ok    = r_mul.ok && (n_edge.e_lo < n_edge.e_hi);
        n_edge.p_lo  = signed'({8'b0, r_mul.prod_p}) - 32'(PI_FIX);
        n_edge.p_hi  = n_edge.p_lo + signed'({17'b0, r_phi_width});
    end

    always_ff @(posedge i_clk) begin
        r_edge <= n_edge;
    end

    // ---- result register: saturation, centres, zeroing when not found --------
    logic r_valid;
    logic r_found;
    logic [CW-1:0] r_code;
    t_q r_eta_low, r_eta_high, r_phi_low, r_phi_high, r_eta_mid, r_phi_mid;

    always_ff @(posedge i_clk) begin
        r_valid <= r_edge.valid & i_rst_n;
        r_found <= r_edge.valid & r_edge.ok & i_rst_n;
        if (r_edge.ok) begin
            r_code     <= r_edge.code;
            r_eta_low  <= sat16(33'(r_edge.e_lo));
            r_eta_high <= sat16(33'(r_edge.e_hi));
            r_phi_low  <= sat16(33'(r_edge.p_lo));
            r_phi_high <= sat16(33'(r_edge.p_hi));
            r_eta_mid  <= sat16((33'(r_edge.e_lo) + 33'(r_edge.e_hi)) >>> 1);
            r_phi_mid  <= sat16((33'(r_edge.p_lo) + 33'(r_edge.p_hi)) >>> 1);
        end else begin
            r_code     <= '0;
            r_eta_low  <= '0;
            r_eta_high <= '0;
            r_phi_low  <= '0;
            r_phi_high <= '0;
            r_eta_mid  <= '0;
            r_phi_mid  <= '0;
        end
    end

    assign o_valid       = r_valid;
    assign o_found       = r_found;
    assign o_cell_code   = r_code;
    assign o_side_out    = r_code[ETA_INDEX_BITS+PHI_INDEX_BITS];
    assign o_eta_bin_out = r_code[ETA_INDEX_BITS+PHI_INDEX_BITS-1:PHI_INDEX_BITS];
    assign o_phi_bin_out = r_code[PHI_INDEX_BITS-1:0];
    assign o_eta_low     = r_eta_low;
    assign o_eta_high    = r_eta_high;
    assign o_phi_low     = r_phi_low;
    assign o_phi_high    = r_phi_high;
    assign o_eta_mid     = r_eta_mid;
    assign o_phi_mid     = r_phi_mid;

`ifndef ASSERT_OFF
    a_found_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_found |-> o_valid)
        else $error("found raised without a result strobe");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("request did not produce a result at the pipeline latency");

    a_eta_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_found |-> (o_eta_low <= o_eta_high))
        else $error("eta edges out of order on a found cell");

    a_neg_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_found && !o_side_out) |-> (o_eta_high <= 0))
        else $error("negative-side cell reaches above zero eta");

    a_pos_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_found && o_side_out) |-> (o_eta_low >= 0))
        else $error("positive-side cell reaches below zero eta");
`endif

endmodule

// ===== bench/eta_phi_cell_locator_test.sv =====
// Self-checking bench for the eta/phi cell locator: directed table, then random requests.
`timescale 1ns / 100ps

module eta_phi_cell_locator_test;
    import epcl_pkg::*;

    localparam longint PI_FIX     = 12868;      // pi in Q4.12, rounded
    localparam longint TWO_PI_FIX = 2 * PI_FIX;
    localparam int     DRAIN      = 30;         // pipeline is 23 deep
    localparam int     LIMIT      = 200000;     // cycle budget, several times the slowest run
    localparam int     N_DIR      = 21;
    localparam int     N_PHASE    = 9;
    localparam int     PER_PHASE  = 60;

    typedef struct packed {
        t_op        op;
        t_q         eta;
        t_q         phi;
        logic [3:0] layer;
        logic       side;
        logic [9:0] ebin;
        logic [7:0] pbin;
    } t_req;

    typedef struct packed {
        logic        found;
        logic [22:0] code;
        logic        side;
        logic [9:0]  ebin;
        logic [7:0]  pbin;
        t_q          eta_lo;
        t_q          eta_hi;
        t_q          phi_lo;
        t_q          phi_hi;
        t_q          eta_c;
        t_q          phi_c;
    } t_cell;

    // how the expected result of a table row is obtained
    typedef enum logic { BY_MODEL, NOT_FOUND } t_row_kind;

    typedef struct packed {
        t_row_kind kind;
        t_req      req;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_operation;
    t_q          i_eta_in;
    t_q          i_phi_in;
    logic [3:0]  i_layer_in;
    logic        i_side_in;
    logic [9:0]  i_eta_bin_in;
    logic [7:0]  i_phi_bin_in;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg_addr   i_cfg_index;
    t_cfg_data   i_cfg_data;
    logic        o_valid;
    logic        o_found;
    logic [22:0] o_cell_code;
    logic        o_side_out;
    logic [9:0]  o_eta_bin_out;
    logic [7:0]  o_phi_bin_out;
    t_q          o_eta_low;
    t_q          o_eta_high;
    t_q          o_phi_low;
    t_q          o_phi_high;
    t_q          o_eta_mid;
    t_q          o_phi_mid;

    // bench copy of the register file
    logic [3:0]  layer_reg;
    logic [14:0] max_eta_reg;
    logic [14:0] eta_w_reg;
    logic [14:0] phi_w_reg;
    logic [10:0] eta_n_reg;
    logic [8:0]  phi_n_reg;

    t_cell       cells_due[$];   // expected cells, oldest first
    int          n_errors = 0;
    int          n_cycles = 0;
    t_dir_row    dir_rows[N_DIR];

    eta_phi_cell_locator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_operation  (i_operation),
        .i_eta_in     (i_eta_in),
        .i_phi_in     (i_phi_in),
        .i_layer_in   (i_layer_in),
        .i_side_in    (i_side_in),
        .i_eta_bin_in (i_eta_bin_in),
        .i_phi_bin_in (i_phi_bin_in),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_found      (o_found),
        .o_cell_code  (o_cell_code),
        .o_side_out   (o_side_out),
        .o_eta_bin_out(o_eta_bin_out),
        .o_phi_bin_out(o_phi_bin_out),
        .o_eta_low    (o_eta_low),
        .o_eta_high   (o_eta_high),
        .o_phi_low    (o_phi_low),
        .o_phi_high   (o_phi_high),
        .o_eta_mid    (o_eta_mid),
        .o_phi_mid    (o_phi_mid)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // clamp to the signed 16-bit range
    function automatic t_q clamp_q(input longint v);
        if (v > 32767) begin
            return 16'sh7fff;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return t_q'(v);
    endfunction

    // cell that a request should resolve to under the current registers
    function automatic t_cell predict_cell(input t_req r);
        t_cell  c;
        longint lyr, sd, ei, pb, eta, phi, wr, mid;
        longint mx, de, dp, ne, np, emin, emax, pmin, pmax;
        c  = '0;
        mx = max_eta_reg;
        de = eta_w_reg;
        dp = phi_w_reg;
        ne = eta_n_reg;
        np = phi_n_reg;
        if (r.op == OP_LOCATE) begin
            eta = r.eta;
            phi = r.phi;
            if (de == 0 || dp == 0) return c;
            if (eta < -mx || eta > mx) return c;
            // shift phi by pi and fold into one turn
            wr = (phi + PI_FIX) % TWO_PI_FIX;
            if (wr < 0) wr = wr + TWO_PI_FIX;
            if (eta == mx) begin
                ei = ne - 1;
            end else if (eta == 0) begin
                ei = ne / 2;
            end else begin
                ei = (eta + mx) / de;
            end
            pb  = wr / dp;
            lyr = layer_reg;
            sd  = (eta < 0) ? 0 : 1;
        end else begin
            lyr = r.layer;
            sd  = r.side;
            ei  = r.ebin;
            pb  = r.pbin;
        end
        if (lyr != layer_reg || ei < 0 || ei >= ne || pb < 0 || pb >= np) return c;
        if (ei > 1023 || pb > 255) return c;
        // side rules around the middle bin
        mid = ne / 2;
        if (ne % 2 == 0) begin
            if (sd != ((ei < mid) ? 0 : 1)) return c;
        end else if ((ei < mid && sd != 0) || (ei > mid && sd != 1)) begin
            return c;
        end
        emin = -mx + ei * de;
        emax = emin + de;
        if (sd == 0) begin
            if (emax > 0) emax = 0;
        end else begin
            if (emin < 0) emin = 0;
        end
        if (ne % 2 == 0) begin
            if (ei == mid - 1) begin
                emax = 0;
            end else if (ei == mid) begin
                emin = 0;
            end
        end
        if (!(emin < emax)) return c;
        pmin = -PI_FIX + pb * dp;
        pmax = pmin + dp;
        c.found  = 1'b1;
        c.code   = {lyr[3:0], sd[0], ei[9:0], pb[7:0]};
        c.side   = sd[0];
        c.ebin   = ei[9:0];
        c.pbin   = pb[7:0];
        c.eta_lo = clamp_q(emin);
        c.eta_hi = clamp_q(emax);
        c.phi_lo = clamp_q(pmin);
        c.phi_hi = clamp_q(pmax);
        c.eta_c  = clamp_q((emin + emax) >>> 1);
        c.phi_c  = clamp_q((pmin + pmax) >>> 1);
        return c;
    endfunction

    // put a request on the port and hold it until the block takes it
    task automatic send_request(input t_req r, input t_row_kind kind);
        start        <= 1'b1;
        i_operation  <= r.op;
        i_eta_in     <= r.eta;
        i_phi_in     <= r.phi;
        i_layer_in   <= r.layer;
        i_side_in    <= r.side;
        i_eta_bin_in <= r.ebin;
        i_phi_bin_in <= r.pbin;
        do @(posedge i_clk); while (busy);
        if (kind == NOT_FOUND) begin
            cells_due.push_back('0);
        end else begin
            cells_due.push_back(predict_cell(r));
        end
    endtask

    // sender gaps: idle with probability pct per cycle
    task automatic idle_gap(input int pct);
        while ($urandom_range(99) < pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // valid is left high between writes; the caller drops it after the last one
    task automatic write_reg(input t_cfg_idx idx, input int unsigned val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= t_cfg_data'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SAMPLING_LAYER: layer_reg   = val[3:0];
            CFG_MAX_ABS_ETA:    max_eta_reg = val[14:0];
            CFG_ETA_WIDTH:      eta_w_reg   = val[14:0];
            CFG_PHI_WIDTH:      phi_w_reg   = val[14:0];
            CFG_ETA_BIN_COUNT:  eta_n_reg   = val[10:0];
            CFG_PHI_BIN_COUNT:  phi_n_reg   = val[8:0];
            default: ;
        endcase
    endtask

    // mostly well-formed addresses and in-span coordinates, some raw noise
    function automatic t_req random_request();
        t_req   r;
        longint e, mx;
        int     hi, mid;
        r  = t_req'(56'({$urandom, $urandom}));
        mx = max_eta_reg;
        if ($urandom_range(9) < 2) return r;
        if (r.op == OP_LOCATE) begin
            case ($urandom_range(9))
                0:       e = mx;
                1:       e = -mx;
                2:       e = 0;
                default: e = longint'($urandom_range(2 * mx + 8)) - mx - 4;
            endcase
            r.eta = clamp_q(e);
        end else begin
            if ($urandom_range(9) != 0) r.layer = layer_reg;
            hi     = (eta_n_reg > 1023) ? 1023 : eta_n_reg;
            r.ebin = 10'($urandom_range(hi));
            hi     = (phi_n_reg > 255) ? 255 : phi_n_reg;
            r.pbin = 8'($urandom_range(hi));
            mid    = eta_n_reg / 2;
            r.side = (r.ebin >= mid);
            if ((eta_n_reg % 2) && r.ebin == mid) r.side = 1'($urandom_range(1));
            if ($urandom_range(9) == 0) r.side = ~r.side;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    // result side: the block cannot be stalled, so each strobe is checked at once
    always @(posedge i_clk) begin
        t_cell want;
        if (i_rst_n && o_valid) begin
            if (cells_due.size() == 0) begin
                $error("result with no request outstanding");
                n_errors++;
            end else begin
                want = cells_due.pop_front();
                check_field("found",       want.found,  o_found);
                check_field("cell_code",   want.code,   o_cell_code);
                check_field("side_out",    want.side,   o_side_out);
                check_field("eta_bin_out", want.ebin,   o_eta_bin_out);
                check_field("phi_bin_out", want.pbin,   o_phi_bin_out);
                check_field("eta_low",     want.eta_lo, o_eta_low);
                check_field("eta_high",    want.eta_hi, o_eta_high);
                check_field("phi_low",     want.phi_lo, o_phi_low);
                check_field("phi_high",    want.phi_hi, o_phi_high);
                check_field("eta_mid",     want.eta_c,  o_eta_mid);
                check_field("phi_mid",     want.phi_c,  o_phi_mid);
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > LIMIT) begin
            $display("eta_phi_cell_locator_test failed");
            $finish;
        end
    end

    initial begin
        // per phase: layer, max eta, eta width, phi width, eta count, phi count
        static int unsigned cfg_set[N_PHASE][6] = '{
            '{0,  10240, 512,   402,   40,   64},
            '{15, 10240, 512,   402,   40,   64},
            '{3,  1000,  200,   1000,  11,   26},
            '{0,  32767, 32767, 25736, 2,    1},
            '{7,  1,     1,     1,     1,    256},
            '{9,  20480, 40,    101,   1024, 255},
            '{5,  4096,  0,     0,     7,    2},
            '{12, 32767, 64,    402,   2047, 511},
            '{0,  0,     0,     0,     0,    0}
        };
        static int idle_pct[N_PHASE] = '{0, 60, 38, 0, 60, 38, 0, 60, 38};

        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_operation  = OP_LOCATE;
        i_eta_in     = '0;
        i_phi_in     = '0;
        i_layer_in   = '0;
        i_side_in    = 1'b0;
        i_eta_bin_in = '0;
        i_phi_bin_in = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_SAMPLING_LAYER;
        i_cfg_data   = '0;
        layer_reg    = 4'd0;
        max_eta_reg  = 15'd10240;
        eta_w_reg    = 15'd512;
        phi_w_reg    = 15'd402;
        eta_n_reg    = 11'd40;
        phi_n_reg    = 9'd64;

        // directed rows, run under the reset register values
        dir_rows = '{
            '{BY_MODEL,  '{OP_LOCATE,   16'sd10240,  16'sd0,      4'd0, 1'b0, 10'd0,    8'd0}},
            '{BY_MODEL,  '{OP_LOCATE,   16'sd0,      16'sd100,    4'd0, 1'b0, 10'd0,    8'd0}},
            '{BY_MODEL,  '{OP_LOCATE,  -16'sd10240,  16'sd0,      4'd0, 1'b0, 10'd0,    8'd0}},
            '{NOT_FOUND, '{OP_LOCATE,   16'sd10241,  16'sd0,      4'd0, 1'b0, 10'd0,    8'd0}},
            '{NOT_FOUND, '{OP_LOCATE,  -16'sd10241,  16'sd0,      4'd0, 1'b0, 10'd0,    8'd0}},
            '{NOT_FOUND, '{OP_LOCATE,   16'sh7fff,   16'sd0,      4'd0, 1'b0, 10'd0,    8'd0}},
            '{NOT_FOUND, '{OP_LOCATE,   16'sh8000,   16'sd0,      4'd0, 1'b0, 10'd0,    8'd0}},
            '{BY_MODEL,  '{OP_LOCATE,   16'sd5,      16'sh7fff,   4'd0, 1'b0, 10'd0,    8'd0}},
            '{BY_MODEL,  '{OP_LOCATE,  -16'sd5,      16'sh8000,   4'd0, 1'b0, 10'd0,    8'd0}},
            '{BY_MODEL,  '{OP_LOCATE,   16'sd777,    16'sd12868,  4'd0, 1'b0, 10'd0,    8'd0}},
            '{BY_MODEL,  '{OP_LOCATE,  -16'sd777,   -16'sd12868,  4'd0, 1'b0, 10'd0,    8'd0}},
            '{BY_MODEL,  '{OP_DESCRIBE, 16'sd0,      16'sd0,      4'd0, 1'b0, 10'd0,    8'd0}},
            '{NOT_FOUND, '{OP_DESCRIBE, 16'sd0,      16'sd0,      4'd1, 1'b0, 10'd0,    8'd0}},
            '{NOT_FOUND, '{OP_DESCRIBE, 16'sd0,      16'sd0,      4'd0, 1'b1, 10'd40,   8'd0}},
            '{NOT_FOUND, '{OP_DESCRIBE, 16'sd0,      16'sd0,      4'd0, 1'b1, 10'd39,   8'd64}},
            '{NOT_FOUND, '{OP_DESCRIBE, 16'sd0,      16'sd0,      4'hf, 1'b1, 10'd1023, 8'd255}},
            // side against the middle of an even count
            '{NOT_FOUND, '{OP_DESCRIBE, 16'sd0,      16'sd0,      4'd0, 1'b1, 10'd19,   8'd3}},
            '{NOT_FOUND, '{OP_DESCRIBE, 16'sd0,      16'sd0,      4'd0, 1'b0, 10'd20,   8'd3}},
            '{BY_MODEL,  '{OP_DESCRIBE, 16'sd0,      16'sd0,      4'd0, 1'b1, 10'd20,   8'd3}},
            '{BY_MODEL,  '{OP_DESCRIBE, 16'sd0,      16'sd0,      4'd0, 1'b0, 10'd19,   8'd3}},
            '{BY_MODEL,  '{OP_DESCRIBE, 16'sd0,      16'sd0,      4'd0, 1'b1, 10'd39,   8'd63}}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            send_request(dir_rows[k].req, dir_rows[k].kind);
        end
        start <= 1'b0;

        for (int ph = 0; ph < N_PHASE; ph++) begin
            // registers only change once the pipeline has emptied
            while (cells_due.size() != 0) @(posedge i_clk);
            repeat (DRAIN) @(posedge i_clk);
            if (ph == N_PHASE - 1) begin
                cfg_set[ph] = '{$urandom_range(15), $urandom_range(32767, 1),
                                $urandom_range(4096, 1), $urandom_range(25736, 1),
                                $urandom_range(64, 1), $urandom_range(256, 1)};
            end
            write_reg(CFG_SAMPLING_LAYER, cfg_set[ph][0]);
            write_reg(CFG_MAX_ABS_ETA,    cfg_set[ph][1]);
            write_reg(CFG_ETA_WIDTH,      cfg_set[ph][2]);
            write_reg(CFG_PHI_WIDTH,      cfg_set[ph][3]);
            write_reg(CFG_ETA_BIN_COUNT,  cfg_set[ph][4]);
            write_reg(CFG_PHI_BIN_COUNT,  cfg_set[ph][5]);
            i_cfg_valid <= 1'b0;
            for (int n = 0; n < PER_PHASE; n++) begin
                send_request(random_request(), BY_MODEL);
                idle_gap(idle_pct[ph]);
            end
            start <= 1'b0;
        end

        while (cells_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("eta_phi_cell_locator_test passed");
        end else begin
            $display("eta_phi_cell_locator_test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/epcl_pkg.sv
rtl/core/eta_phi_cell_locator.sv
bench/eta_phi_cell_locator_test.sv
